>>> rtl/mrpkf_pkg.sv
// Shared types, constants and round functions for the peel key filter.
// Depends on nothing; imported by every module of the block.
package mrpkf_pkg;

    localparam int MAX_EXTRA_ROUNDS = 3;
    localparam int NUM_ROUNDS       = MAX_EXTRA_ROUNDS + 2;
    localparam int RND_W            = $clog2(NUM_ROUNDS);
    localparam int LAST_RC_INDEX    = 34;
    localparam int RC_COUNT         = 35;
    localparam int S_DATA_W         = 400;
    localparam int M_DATA_W         = 136;

    localparam logic [3:0] PEEL_SBOX [16] = '{
        4'h1, 4'hf, 4'hb, 4'h0, 4'hc, 4'h5, 4'h2, 4'he,
        4'h6, 4'ha, 4'hd, 4'h4, 4'h8, 4'h3, 4'h7, 4'h9
    };

    localparam logic [5:0] RC_TABLE [RC_COUNT] = '{
        6'd2,  6'd33, 6'd16, 6'd9,  6'd36, 6'd19, 6'd40, 6'd53, 6'd26, 6'd13,
        6'd38, 6'd51, 6'd56, 6'd61, 6'd62, 6'd31, 6'd14, 6'd7,  6'd34, 6'd49,
        6'd24, 6'd45, 6'd54, 6'd59, 6'd28, 6'd47, 6'd22, 6'd43, 6'd20, 6'd11,
        6'd4,  6'd3,  6'd32, 6'd17, 6'd8
    };

    // state bit that each round-constant bit lands on
    localparam int RC_POS [6] = '{8, 13, 19, 35, 67, 106};

    typedef struct packed {
        logic [127:0] key_orig;
        logic [127:0] round_key;
        logic [127:0] text_a;
        logic [127:0] text_b;
        logic [4:0]   nib_sel;
        logic [3:0]   target;
    } mrpkf_item_t;

    typedef struct packed {
        logic         passes;
        logic [127:0] key;
    } mrpkf_result_t;

    function automatic int perm_dest(input int i);
        int q;
        int b;
        q = (i % 16) / 4;
        b = i % 4;
        return 4 * (i / 16) + 32 * ((3 * q + b) % 4) + b;
    endfunction

    function automatic logic [127:0] perm_forward(input logic [127:0] s);
        logic [127:0] r;
        for (int i = 0; i < 128; i++) begin
            r[perm_dest(i)] = s[i];
        end
        return r;
    endfunction

    function automatic logic [127:0] perm_inverse(input logic [127:0] s);
        logic [127:0] r;
        for (int i = 0; i < 128; i++) begin
            r[i] = s[perm_dest(i)];
        end
        return r;
    endfunction

    function automatic logic [127:0] peel(input logic [127:0] s,
                                          input logic [127:0] key,
                                          input logic [5:0]   rc);
        logic [127:0] t;
        logic [127:0] p;
        logic [127:0] r;
        t = s ^ key;
        for (int k = 0; k < 6; k++) begin
            t[RC_POS[k]] = t[RC_POS[k]] ^ rc[k];
        end
        p = perm_inverse(t);
        for (int n = 0; n < 32; n++) begin
            r[4*n +: 4] = PEEL_SBOX[p[4*n +: 4]];
        end
        return r;
    endfunction

endpackage

>>> rtl/mrpkf_round.sv
// One peel round (or pass-through) as a pipeline stage with a valid bit.
// Depends on mrpkf_pkg (item type, peel function, constant table).
module mrpkf_round
    import mrpkf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [RND_W-1:0] round_idx,
    input  logic [RND_W-1:0] last_round,
    input  logic             s_valid,
    output logic             s_ready,
    input  mrpkf_item_t      s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output mrpkf_item_t      m_data
);

    logic        valid_reg;
    mrpkf_item_t data_reg;
    mrpkf_item_t data_next;
    logic [5:0]  rc_idx;
    logic [5:0]  rc_val;

    assign rc_idx = 6'(LAST_RC_INDEX) - 6'(round_idx);
    assign rc_val = RC_TABLE[rc_idx];

    always_comb begin
        data_next = s_data;
        if (round_idx <= last_round) begin
            data_next.text_a    = peel(s_data.text_a, s_data.round_key, rc_val);
            data_next.text_b    = peel(s_data.text_b, s_data.round_key, rc_val);
            data_next.round_key = {s_data.round_key[126:0], s_data.round_key[127]};
        end
    end

    assign s_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

>>> rtl/mrpkf_check.sv
// Final stage: nibble difference compare and registered result word.
// Depends on mrpkf_pkg (item and result types).
module mrpkf_check
    import mrpkf_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mrpkf_item_t   s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output mrpkf_result_t m_data
);

    logic          valid_reg;
    mrpkf_result_t res_reg;
    mrpkf_result_t res_next;
    logic [3:0]    diff;

    assign diff = s_data.text_a[4*s_data.nib_sel +: 4] ^ s_data.text_b[4*s_data.nib_sel +: 4];

    always_comb begin
        res_next.passes = (diff == s_data.target);
        res_next.key    = s_data.key_orig;
    end

    assign s_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = res_reg;

endmodule

>>> rtl/multi_round_peel_key_filter.sv
// Top level of the last-rounds differential key filter.
// Depends on mrpkf_pkg, mrpkf_round and mrpkf_check.
//
//  channel   dir   handshake            word contents
//  s_        in    s_tvalid/s_tready    key, two ciphertexts, nibble select, target
//  m_        out   m_tvalid/m_tready    pass flag, echoed key
//  cfg_      in    cfg_valid/cfg_ready  extra peel round count
//
// Each word passes one register per peel round and one for the compare,
// whatever the extra round count is: rounds past the configured count
// pass the word through unchanged. One word is accepted per cycle while
// m_ does not stall. Reset (aresetn low, synchronous) clears all stage
// valid bits and sets the extra round count to 1. A stall at m_ holds each
// stage; a stage with an empty register still accepts, so bubbles close up.
module multi_round_peel_key_filter
    import mrpkf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // config word: [1:0] extra peel round count
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data,
    // [63:0] key_low, [127:64] key_high, [191:128] first_text_low,
    // [255:192] first_text_high, [319:256] second_text_low,
    // [383:320] second_text_high, [388:384] nibble_select,
    // [392:389] target_diff, [399:393] zero
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    // [0] passes, [64:1] key_low_out, [128:65] key_high_out, [135:129] zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic [1:0]       extra_reg;
    logic [RND_W-1:0] extra_w;
    logic [RND_W-1:0] last_round;

    // user must write config only while the pipe is empty; block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            extra_reg <= 2'd1;
        end else if (cfg_valid) begin
            extra_reg <= cfg_data;
        end
    end

    // saturate to the built round count
    assign extra_w    = RND_W'(extra_reg);
    assign last_round = (extra_w > RND_W'(MAX_EXTRA_ROUNDS))
                        ? RND_W'(MAX_EXTRA_ROUNDS + 1)
                        : RND_W'(extra_w + RND_W'(1));

    // input unpack; the last round key is the forward-permuted candidate
    mrpkf_item_t in_item;

    always_comb begin
        in_item.key_orig  = s_tdata[127:0];
        in_item.round_key = perm_forward(s_tdata[127:0]);
        in_item.text_a    = s_tdata[255:128];
        in_item.text_b    = s_tdata[383:256];
        in_item.nib_sel   = s_tdata[388:384];
        in_item.target    = s_tdata[392:389];
    end

    logic        stg_valid [NUM_ROUNDS+1];
    logic        stg_ready [NUM_ROUNDS+1];
    mrpkf_item_t stg_data  [NUM_ROUNDS+1];

    assign stg_valid[0] = s_tvalid;
    assign stg_data[0]  = in_item;
    assign s_tready     = stg_ready[0];

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        mrpkf_round u_round (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .round_idx  (RND_W'(g)),
            .last_round (last_round),
            .s_valid    (stg_valid[g]),
            .s_ready    (stg_ready[g]),
            .s_data     (stg_data[g]),
            .m_valid    (stg_valid[g+1]),
            .m_ready    (stg_ready[g+1]),
            .m_data     (stg_data[g+1])
        );
    end

    mrpkf_result_t res;

    mrpkf_check u_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (stg_valid[NUM_ROUNDS]),
        .s_ready (stg_ready[NUM_ROUNDS]),
        .s_data  (stg_data[NUM_ROUNDS]),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (res)
    );

    assign m_tdata = {7'd0, res.key, res.passes};

endmodule

>>> sim/tb_multi_round_peel_key_filter.sv
// Self-checking testbench for multi_round_peel_key_filter: peels random and
// directed ciphertext pairs under every extra round setting and checks each word.
// Depends on mrpkf_pkg (bus widths, round count) and the RTL of the block.
module tb_multi_round_peel_key_filter;
    import mrpkf_pkg::*;

    // Inverse S-box, entry n at bits [4n+3:4n].
    localparam logic [63:0]  SBOX_INV    = 64'h97384da6e25c0bf1;
    // Round constants counted back from the last round: j = 0 uses the
    // last entry of the schedule, j = 4 the fifth from the end.
    localparam logic [29:0]  RC_BACK     = {6'd4, 6'd3, 6'd32, 6'd17, 6'd8};
    // State bit that round-constant bit k flips, 7 bits per entry.
    localparam logic [41:0]  RC_SPOT     = {7'd106, 7'd67, 7'd35, 7'd19, 7'd13, 7'd8};
    // Extra round count written before each random phase, phase p at [2p+1:2p].
    localparam logic [9:0]   PHASE_ROUNDS = {2'd3, 2'd1, 2'd2, 2'd3, 2'd0};
    localparam int           NUM_PHASES   = 5;
    localparam int           PHASE_WORDS  = 366;
    localparam int           SETTLE       = NUM_ROUNDS + 4;
    localparam int           HOLD_CYCLES  = 250;
    localparam int           LIMIT        = 200000;
    // target choice for a queued word
    localparam int           TGT_HIT      = 0;
    localparam int           TGT_MISS     = 1;
    localparam int           TGT_ZERO     = 2;
    localparam int           TGT_ONES     = 3;
    localparam int           TGT_RAND     = 4;

    typedef struct packed {
        logic [127:0] key;
        logic [127:0] text_a;
        logic [127:0] text_b;
        logic [4:0]   nib;
        logic [3:0]   target;
    } filter_word_t;

    typedef struct packed {
        logic         passes;
        logic [127:0] key;
    } verdict_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    filter_word_t word_q[$];      // words waiting to be offered
    verdict_t     verdict_q[$];   // verdicts owed by the block, oldest first
    filter_word_t cur_word;
    verdict_t     want;

    logic [1:0] rounds_cfg;       // mirror of the extra round count
    logic       idle_ok;          // random bubbles allowed on both sides
    logic       hold_go;
    logic       hold_off;
    int         gap_left;
    int         stall_left;
    int         cycle_cnt;
    int         backpressure;
    int         checked;
    int         pass_cnt;
    int         mismatches;

    multi_round_peel_key_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Where bit i of the state lands under the forward bit permutation:
    // nibble column (i/16) stays, (3 * q + lane) % 4 picks one of four quarters.
    function automatic int bit_home(input int i);
        int lane;
        int q;
        lane = i % 4;
        q    = (i % 16) / 4;
        return 4 * (i / 16) + 32 * ((3 * q + lane) % 4) + lane;
    endfunction

    function automatic logic [127:0] scatter(input logic [127:0] s);
        logic [127:0] r;
        int           i;
        r = '0;
        for (i = 0; i < 128; i++) r[bit_home(i)] = s[i];
        return r;
    endfunction

    function automatic logic [127:0] gather(input logic [127:0] s);
        logic [127:0] r;
        int           i;
        r = '0;
        for (i = 0; i < 128; i++) r[i] = s[bit_home(i)];
        return r;
    endfunction

    // One round backwards: key, round constant, inverse permutation, S-box.
    function automatic logic [127:0] undo_round(input logic [127:0] s,
                                                input logic [127:0] rk,
                                                input int           j);
        logic [127:0] t;
        logic [127:0] r;
        logic [5:0]   c;
        int           k;
        int           n;
        t = s ^ rk;
        c = RC_BACK[6*j +: 6];
        for (k = 0; k < 6; k++)
            if (c[k]) t[RC_SPOT[7*k +: 7]] = ~t[RC_SPOT[7*k +: 7]];
        t = gather(t);
        for (n = 0; n < 32; n++) r[4*n +: 4] = SBOX_INV[4*t[4*n +: 4] +: 4];
        return r;
    endfunction

    // Difference of the two peeled texts at the selected nibble.
    function automatic logic [3:0] peeled_diff(input filter_word_t w,
                                               input logic [1:0]   extra);
        logic [127:0] rk;
        logic [127:0] a;
        logic [127:0] b;
        int           j;
        rk = scatter(w.key);
        a  = w.text_a;
        b  = w.text_b;
        for (j = 0; j <= 1 + int'(extra); j++) begin
            a  = undo_round(a, rk, j);
            b  = undo_round(b, rk, j);
            rk = {rk[126:0], rk[127]};
        end
        return a[4*w.nib +: 4] ^ b[4*w.nib +: 4];
    endfunction

    // ---------------------------------------------------------------
    // Clock, cycle count, timeout
    // ---------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (s_tvalid && !s_tready) backpressure <= backpressure + 1;
    end

    initial begin
        while (cycle_cnt < LIMIT) @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    // ---------------------------------------------------------------
    // Input driver: offers words from word_q, predicts on acceptance.
    // s_tvalid gets at most one assignment per edge.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                want.passes = (peeled_diff(cur_word, rounds_cfg) == cur_word.target);
                want.key    = cur_word.key;
                verdict_q.push_back(want);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (idle_ok && cycle_cnt[6] && word_q.size() != 0 &&
                             $urandom_range(0, 3) == 0) begin
                    // start a random bubble; gap_left holds what remains of it
                    gap_left = $urandom_range(0, 3);
                    s_tvalid <= 1'b0;
                end else if (word_q.size() != 0) begin
                    cur_word = word_q.pop_front();
                    s_tdata  <= {7'b0, cur_word.target, cur_word.nib, cur_word.text_b,
                                 cur_word.text_a, cur_word.key};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Output monitor: checks every accepted result word, drives m_tready.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result word, got passes %0b key %h", $time,
                         m_tdata[0], m_tdata[128:1]);
                mismatches = mismatches + 1;
            end else begin
                automatic verdict_t exp_v = verdict_q.pop_front();
                checked <= checked + 1;
                if (exp_v.passes) pass_cnt <= pass_cnt + 1;
                if (m_tdata[0] !== exp_v.passes) begin
                    $display("%0t: passes expected %0b actual %0b", $time,
                             exp_v.passes, m_tdata[0]);
                    mismatches = mismatches + 1;
                end
                if (m_tdata[64:1] !== exp_v.key[63:0]) begin
                    $display("%0t: key_low_out expected %h actual %h", $time,
                             exp_v.key[63:0], m_tdata[64:1]);
                    mismatches = mismatches + 1;
                end
                if (m_tdata[128:65] !== exp_v.key[127:64]) begin
                    $display("%0t: key_high_out expected %h actual %h", $time,
                             exp_v.key[127:64], m_tdata[128:65]);
                    mismatches = mismatches + 1;
                end
            end
        end
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_ok && cycle_cnt[7] && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Long receiver hold-off: the sender keeps offering, so the pipe fills
    // and s_tready must drop.
    initial begin
        hold_off = 1'b0;
        wait (hold_go);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic push_word(input logic [127:0] key, input logic [127:0] a,
                             input logic [127:0] b, input int nib,
                             input int tmode, input logic [1:0] extra);
        filter_word_t w;
        logic [3:0]   d;
        w.key    = key;
        w.text_a = a;
        w.text_b = b;
        w.nib    = nib[4:0];
        w.target = '0;
        d = peeled_diff(w, extra);
        // true difference (a hit), complement (a miss), zero target,
        // all-ones target, otherwise random
        case (tmode)
            TGT_HIT:  w.target = d;
            TGT_MISS: w.target = ~d;
            TGT_ZERO: w.target = 4'h0;
            TGT_ONES: w.target = 4'hf;
            default:  w.target = 4'($urandom_range(0, 15));
        endcase
        word_q.push_back(w);
    endtask

    task automatic queue_random(input int count, input logic [1:0] extra);
        logic [127:0] key;
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] flip;
        int           i;
        for (i = 0; i < count; i++) begin
            key = rand128();
            if ($urandom_range(0, 31) == 0) key = '0;
            if ($urandom_range(0, 31) == 0) key = '1;
            a = rand128();
            // mostly pairs with a small input difference, as in a real
            // differential attack; the rest unrelated or identical texts
            flip = '0;
            case ($urandom_range(0, 5))
                0, 1: flip[4*$urandom_range(0, 31) +: 4] = 4'($urandom_range(1, 15));
                2:    flip[$urandom_range(0, 127)] = 1'b1;
                3:    flip = rand128();
                4:    flip[4*$urandom_range(0, 31) +: 4] = 4'($urandom_range(1, 15));
                default: flip = '0;
            endcase
            b = a ^ flip;
            push_word(key, a, b, $urandom_range(0, 31),
                      ($urandom_range(0, 2) == 0) ? TGT_HIT : TGT_RAND, extra);
        end
    endtask

    // Idle point: all words offered, all results back, then let the
    // pipeline settle before touching the register.
    task automatic drain();
        while (word_q.size() != 0 || s_tvalid || verdict_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_rounds(input logic [1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        rounds_cfg = v;
    endtask

    initial begin
        logic [127:0] pk [5];
        logic [127:0] pa [5];
        logic [127:0] pb [5];
        int           p;
        int           n;
        logic [1:0]   r;

        aresetn      <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        m_tready     <= 1'b0;
        idle_ok      = 1'b1;
        hold_go      = 1'b0;
        rounds_cfg   = 2'd1;      // reset value
        cycle_cnt    = 0;
        backpressure = 0;
        checked      = 0;
        pass_cnt     = 0;
        mismatches   = 0;
        gap_left     = 0;
        stall_left   = 0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words under the reset setting: all-zero, all-one,
        // complementary and sparse patterns, nibble selects at both ends,
        // hit, miss, zero and all-ones targets.
        pk[0] = '0;  pa[0] = '0;  pb[0] = '0;
        pk[1] = '1;  pa[1] = '1;  pb[1] = '0;
        pk[2] = '0;  pa[2] = '0;  pb[2] = '1;
        pk[3] = {32{4'h5}};  pa[3] = {32{4'ha}};  pb[3] = '1;
        pk[4] = {1'b1, 126'b0, 1'b1};  pa[4] = rand128();  pb[4] = pa[4] ^ 128'hf;
        for (p = 0; p < 5; p++)
            for (n = 0; n < 4; n++)
                push_word(pk[p], pa[p], pb[p], (n == 0) ? 0 : (n == 1) ? 31 : 15 + n - 1,
                          (p + n) % 4, rounds_cfg);

        for (p = 0; p < NUM_PHASES; p++) begin
            drain();
            r = PHASE_ROUNDS[2*p +: 2];
            write_rounds(r);
            if (p == NUM_PHASES - 1) idle_ok = 1'b0;   // full rate at the end
            queue_random(PHASE_WORDS, r);
            if (p == 1) hold_go = 1'b1;
        end
        drain();

        $display("summary: %0d result words checked, %0d hits, extra peel rounds 1,0,3,2,1,3",
                 checked, pass_cnt);
        $display("summary: input stalled %0d cycles by output back-pressure",
                 backpressure);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
